FILE: hw/rtl/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  localparam int M3I_W  = 32;
  localparam int M3I_F  = 16;
  localparam int M3I_TW = 31;
  localparam int M3I_PW = 2 * M3I_W;
  localparam int M3I_CW = 2 * M3I_W + 1;
  localparam int M3I_DW = 3 * M3I_W + 3;

  typedef logic signed [M3I_W-1:0]  m3i_elem_t;
  typedef logic signed [M3I_CW-1:0] m3i_cof_t;

  typedef struct packed {
    logic signed [M3I_W-1:0] a00;
    logic signed [M3I_W-1:0] a01;
    logic signed [M3I_W-1:0] a02;
    logic signed [M3I_W-1:0] a10;
    logic signed [M3I_W-1:0] a11;
    logic signed [M3I_W-1:0] a12;
    logic signed [M3I_W-1:0] a20;
    logic signed [M3I_W-1:0] a21;
    logic signed [M3I_W-1:0] a22;
  } m3i_req_t;

  typedef struct packed {
    logic signed [M3I_W-1:0] b00;
    logic signed [M3I_W-1:0] b01;
    logic signed [M3I_W-1:0] b02;
    logic signed [M3I_W-1:0] b10;
    logic signed [M3I_W-1:0] b11;
    logic signed [M3I_W-1:0] b12;
    logic signed [M3I_W-1:0] b20;
    logic signed [M3I_W-1:0] b21;
    logic signed [M3I_W-1:0] b22;
    logic                    singular;
  } m3i_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/m3i_cof.sv
`default_nettype none
module m3i_cof import m3i_pkg::*; (
  input  wire logic      clk,
  input  wire m3i_elem_t a   [9],
  output m3i_cof_t       cof [9],
  output m3i_elem_t      a0  [3]
);

  logic signed [M3I_PW-1:0] p0 [9];
  logic signed [M3I_PW-1:0] p1 [9];
  m3i_elem_t                a0_s1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam int R0 = (i == 0) ? 1 : 0;
    localparam int R1 = (i == 2) ? 1 : 2;
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;
      logic signed [M3I_CW-1:0] diff;
      always_ff @(posedge clk) begin
        p0[i*3+j] <= a[R0*3+C0] * a[R1*3+C1];
        p1[i*3+j] <= a[R0*3+C1] * a[R1*3+C0];
      end
      assign diff = M3I_CW'(p0[i*3+j]) - M3I_CW'(p1[i*3+j]);
      always_ff @(posedge clk) begin
        cof[i*3+j] <= (((i + j) % 2) == 1) ? -diff : diff;
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_a0
    always_ff @(posedge clk) begin
      a0_s1[j] <= a[j];
      a0[j]    <= a0_s1[j];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/m3i_det.sv
`default_nettype none
module m3i_det import m3i_pkg::*; #(
  parameter int FRAC_BITS = M3I_F
) (
  input  wire logic                                  clk,
  input  wire m3i_cof_t                              cof  [9],
  input  wire m3i_elem_t                             a0   [3],
  input  wire logic [M3I_TW-1:0]                     thr,
  output logic      [M3I_DW-1:0]                     mag,
  output logic                                       neg  [9],
  output logic      [M3I_CW+2*FRAC_BITS-1:0]         num  [9],
  output logic                                       sing
);

  localparam int NW = M3I_CW + 2 * FRAC_BITS;
  localparam int XW = M3I_DW + M3I_TW + 2 * FRAC_BITS;

  logic signed [2*M3I_W:0]   pl  [3];
  logic signed [2*M3I_W:0]   ph  [3];
  m3i_cof_t                  cof3 [9];
  m3i_cof_t                  cof4 [9];
  logic signed [M3I_DW-1:0]  det;
  logic signed [M3I_DW-1:0]  det_sum;
  logic        [M3I_DW-1:0]  det_abs;

  for (genvar j = 0; j < 3; j++) begin : g_part
    logic signed [M3I_W:0] lo;
    logic signed [M3I_W:0] hi;
    assign lo = $signed({1'b0, cof[j][M3I_W-1:0]});
    assign hi = $signed(cof[j][M3I_CW-1:M3I_W]);
    always_ff @(posedge clk) begin
      pl[j] <= a0[j] * lo;
      ph[j] <= a0[j] * hi;
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (M3I_DW'(ph[j]) <<< M3I_W) + M3I_DW'(pl[j]);
    end
  end

  assign det_abs = det[M3I_DW-1] ? M3I_DW'(-det) : M3I_DW'(det);

  for (genvar k = 0; k < 9; k++) begin : g_num
    logic [M3I_CW-1:0] cabs;
    assign cabs = cof4[k][M3I_CW-1] ? M3I_CW'(-cof4[k]) : M3I_CW'(cof4[k]);
    always_ff @(posedge clk) begin
      cof3[k] <= cof[k];
      cof4[k] <= cof3[k];
      num[k]  <= NW'(cabs) << (2 * FRAC_BITS);
      neg[k]  <= cof4[k][M3I_CW-1] ^ det[M3I_DW-1];
    end
  end

  always_ff @(posedge clk) begin
    det  <= det_sum;
    mag  <= det_abs;
    sing <= (det_abs == '0) || (XW'(det_abs) < (XW'(thr) << (2 * FRAC_BITS)));
  end

endmodule
`default_nettype wire

FILE: hw/rtl/m3i_div_lane.sv
`default_nettype none
module m3i_div_lane import m3i_pkg::*; #(
  parameter int FRAC_BITS = M3I_F
) (
  input  wire logic                          clk,
  input  wire logic [M3I_CW+2*FRAC_BITS-1:0] num,
  input  wire logic [M3I_DW-1:0]             mag,
  input  wire logic                          neg,
  input  wire logic                          sing,
  output m3i_elem_t                          quo,
  output logic                               sing_o
);

  localparam int NW = M3I_CW + 2 * FRAC_BITS;
  localparam int RW = M3I_DW + 1;
  localparam int OW = (NW > M3I_DW + M3I_W) ? NW : M3I_DW + M3I_W;
  localparam int W  = M3I_W;

  logic [RW-1:0]     r   [W+1];
  logic [W-1:0]      qv  [W+1];
  logic [W-1:0]      nl  [W+1];
  logic [M3I_DW-1:0] mg  [W+1];
  logic              ng  [W+1];
  logic              sg  [W+1];
  logic              ov  [W+1];

  always_ff @(posedge clk) begin
    ov[0] <= OW'(num) >= (OW'(mag) << W);
    r[0]  <= RW'(num >> W);
    nl[0] <= num[W-1:0];
    qv[0] <= '0;
    mg[0] <= mag;
    ng[0] <= neg;
    sg[0] <= sing;
  end

  for (genvar g = 0; g < W; g++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {r[g][M3I_DW-1:0], nl[g][W-1-g]};
    assign ge = t >= {1'b0, mg[g]};
    always_ff @(posedge clk) begin
      r[g+1]  <= ge ? t - {1'b0, mg[g]} : t;
      qv[g+1] <= {qv[g][W-2:0], ge};
      nl[g+1] <= nl[g];
      mg[g+1] <= mg[g];
      ng[g+1] <= ng[g];
      sg[g+1] <= sg[g];
      ov[g+1] <= ov[g];
    end
  end

  logic          rnd;
  logic [W:0]    qf;
  logic [W:0]    lim;
  logic [W-1:0]  res_next;

  assign rnd = {r[W][M3I_DW-1:0], 1'b0} >= {1'b0, mg[W]};
  assign qf  = {1'b0, qv[W]} + (W+1)'(rnd);
  assign lim = (W+1)'(1) << (W - 1);

  always_comb begin
    if (sg[W]) begin
      res_next = '0;
    end else if (ng[W]) begin
      res_next = (ov[W] || qf > lim) ? lim[W-1:0] : W'(-qf);
    end else begin
      res_next = (ov[W] || qf >= lim) ? W'(lim - (W+1)'(1)) : qf[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo    <= $signed(res_next);
    sing_o <= sg[W];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/matrix3x3_inverse.sv
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------
// request   | start, busy        | req  (a00..a22, signed Q16.16)
// result    | done (one cycle)   | res  (b00..b22, singular)
// config    | cfg_we             | cfg_wdata (singular_threshold)
//
// A request is taken every cycle; busy stays low. The result of a request
// passes through the cofactor, determinant and magnitude stages, then one
// restoring divider step per quotient bit, plus overflow and round/saturate
// stages. Reset clears the valid pipeline and sets the threshold to 1. The
// receiver cannot stall; no stall path exists.
`default_nettype none
module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int FRAC_BITS = M3I_F
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire m3i_req_t          req,
  output logic                   done,
  output m3i_res_t               res,
  input  wire logic              cfg_we,
  input  wire logic [M3I_TW-1:0] cfg_wdata
);

  localparam int NW  = M3I_CW + 2 * FRAC_BITS;
  localparam int LAT = M3I_W + 7;

  logic [M3I_TW-1:0] thr;
  logic [LAT-1:0]    vld;
  m3i_elem_t         a    [9];
  m3i_cof_t          cof  [9];
  m3i_elem_t         a0   [3];
  logic [M3I_DW-1:0] mag;
  logic              neg  [9];
  logic [NW-1:0]     num  [9];
  logic              sing;
  m3i_elem_t         quo  [9];
  logic              sing_o;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= M3I_TW'(1);
      vld <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign a[0] = req.a00;
  assign a[1] = req.a01;
  assign a[2] = req.a02;
  assign a[3] = req.a10;
  assign a[4] = req.a11;
  assign a[5] = req.a12;
  assign a[6] = req.a20;
  assign a[7] = req.a21;
  assign a[8] = req.a22;

  m3i_cof u_cof (
    .clk (clk),
    .a   (a),
    .cof (cof),
    .a0  (a0)
  );

  m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk  (clk),
    .cof  (cof),
    .a0   (a0),
    .thr  (thr),
    .mag  (mag),
    .neg  (neg),
    .num  (num),
    .sing (sing)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      if (i == 0 && j == 0) begin : g_first
        m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
          .clk    (clk),
          .num    (num[j*3+i]),
          .mag    (mag),
          .neg    (neg[j*3+i]),
          .sing   (sing),
          .quo    (quo[i*3+j]),
          .sing_o (sing_o)
        );
      end else begin : g_rest
        m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
          .clk    (clk),
          .num    (num[j*3+i]),
          .mag    (mag),
          .neg    (neg[j*3+i]),
          .sing   (sing),
          .quo    (quo[i*3+j]),
          .sing_o ()
        );
      end
    end
  end

  assign done         = vld[LAT-1];
  assign res.b00      = quo[0];
  assign res.b01      = quo[1];
  assign res.b02      = quo[2];
  assign res.b10      = quo[3];
  assign res.b11      = quo[4];
  assign res.b12      = quo[5];
  assign res.b20      = quo[6];
  assign res.b21      = quo[7];
  assign res.b22      = quo[8];
  assign res.singular = sing_o;

endmodule
`default_nettype wire

FILE: hw/rtl/m3i_checker.sv
`default_nettype none
module m3i_checker import m3i_pkg::*; #(
  parameter int LAT = M3I_W + 7
) (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire m3i_res_t res
);

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request lost");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.singular) |-> (res.b00 == '0 && res.b01 == '0 && res.b02 == '0 &&
      res.b10 == '0 && res.b11 == '0 && res.b12 == '0 &&
      res.b20 == '0 && res.b21 == '0 && res.b22 == '0))
    else $error("singular result not zero");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
`default_nettype wire

FILE: tb/sv/matrix3x3_inverse_tb.sv
`default_nettype none
module matrix3x3_inverse_tb;
  import m3i_pkg::*;

  localparam int PIPE_DELAY = M3I_W + 7;
  localparam int STALL_LIMIT = 4000;
  localparam int FRAC_BITS_TB = M3I_F;

  typedef logic signed [127:0] swide_t;
  typedef logic [127:0] uwide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  m3i_req_t req = '0;
  logic done;
  m3i_res_t res;
  logic cfg_we = 1'b0;
  logic [M3I_TW-1:0] cfg_wdata = '0;

  logic [M3I_TW-1:0] threshold = 31'd1;
  m3i_res_t inverse_q[$];
  int mismatches = 0;
  int sent = 0;
  int checked = 0;
  int singular_seen = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;

  matrix3x3_inverse dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic m3i_res_t inverse_of(m3i_req_t m, logic [M3I_TW-1:0] thr);
    swide_t a[3][3];
    swide_t cof[3][3];
    swide_t det, mnr, cf;
    uwide_t mag, thr_w, num, q, r, lim;
    logic [M3I_W-1:0] b[9];
    logic neg;
    int r0, r1, c0, c1;
    m3i_res_t o;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    for (int i = 0; i < 3; i++) begin
      r0 = (i == 0) ? 1 : 0;
      r1 = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        mnr = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
        cof[i][j] = ((i + j) % 2 == 1) ? -mnr : mnr;
      end
    end
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    mag = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
    thr_w = uwide_t'(thr) << (2 * FRAC_BITS_TB);
    o = '0;
    if (mag == 0 || mag < thr_w) begin
      o.singular = 1'b1;
      return o;
    end
    lim = uwide_t'(1) << (M3I_W - 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cf = cof[j][i];
        neg = (cf < 0) != (det < 0);
        num = ((cf < 0) ? uwide_t'(-cf) : uwide_t'(cf)) << (2 * FRAC_BITS_TB);
        q = num / mag;
        r = num % mag;
        if ((r << 1) >= mag) q = q + 1;
        if (neg) begin
          if (q > lim) q = lim;
        end else if (q >= lim) begin
          q = lim - 1;
        end
        if (neg) q = -q;
        b[i * 3 + j] = q[M3I_W-1:0];
      end
    end
    o.b00 = b[0]; o.b01 = b[1]; o.b02 = b[2];
    o.b10 = b[3]; o.b11 = b[4]; o.b12 = b[5];
    o.b20 = b[6]; o.b21 = b[7]; o.b22 = b[8];
    o.singular = 1'b0;
    return o;
  endfunction

  task automatic report(string field, logic [M3I_W-1:0] got, logic [M3I_W-1:0] want);
    $display("mismatch at result %0d field %s: got %h want %h", checked, field, got, want);
    mismatches++;
  endtask

  task automatic compare(m3i_res_t got, m3i_res_t want);
    if (got.b00 !== want.b00) report("b00", got.b00, want.b00);
    if (got.b01 !== want.b01) report("b01", got.b01, want.b01);
    if (got.b02 !== want.b02) report("b02", got.b02, want.b02);
    if (got.b10 !== want.b10) report("b10", got.b10, want.b10);
    if (got.b11 !== want.b11) report("b11", got.b11, want.b11);
    if (got.b12 !== want.b12) report("b12", got.b12, want.b12);
    if (got.b20 !== want.b20) report("b20", got.b20, want.b20);
    if (got.b21 !== want.b21) report("b21", got.b21, want.b21);
    if (got.b22 !== want.b22) report("b22", got.b22, want.b22);
    if (got.singular !== want.singular) begin
      report("singular", M3I_W'(got.singular), M3I_W'(want.singular));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (inverse_q.size() == 0) begin
          report("done", M3I_W'(1), M3I_W'(0));
        end else begin
          compare(res, inverse_q.pop_front());
          if (res.singular) singular_seen++;
        end
        checked++;
      end
      if (start && !busy) begin
        inverse_q.push_back(inverse_of(req, threshold));
        sent++;
      end
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(m3i_req_t m);
    while (gaps_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (inverse_q.size() != 0) @(negedge clk);
    repeat (PIPE_DELAY + 4) @(negedge clk);
  endtask

  task automatic set_threshold(logic [M3I_TW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    threshold = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic m3i_req_t diag(logic [M3I_W-1:0] d0, logic [M3I_W-1:0] d1,
                                    logic [M3I_W-1:0] d2);
    m3i_req_t m;
    m = '0;
    m.a00 = d0;
    m.a11 = d1;
    m.a22 = d2;
    return m;
  endfunction

  function automatic logic [M3I_W-1:0] small_elem();
    logic [M3I_W-1:0] v;
    v = $urandom_range(32'h0004_0000);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic m3i_req_t rand_matrix();
    m3i_req_t m;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      m.a00 = small_elem(); m.a01 = small_elem(); m.a02 = small_elem();
      m.a10 = small_elem(); m.a11 = small_elem(); m.a12 = small_elem();
      m.a20 = small_elem(); m.a21 = small_elem(); m.a22 = small_elem();
    end else if (kind < 75) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else if (kind < 88) begin
      m = diag(small_elem(), small_elem(), small_elem());
      m.a01 = $urandom_range(255);
      m.a12 = -$urandom_range(255);
    end else begin
      m.a00 = small_elem(); m.a01 = small_elem(); m.a02 = small_elem();
      m.a10 = small_elem(); m.a11 = small_elem(); m.a12 = small_elem();
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      if ($urandom_range(1)) m.a22 = m.a22 + $urandom_range(3);
    end
    return m;
  endfunction

  task automatic test_directed();
    m3i_req_t m;
    send(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
    send('0);
    send(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000));
    send(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    send(diag(32'h0000_0100, 32'h0000_0100, 32'hFFFF_FF00));
    send(diag(32'h0000_0003, 32'h0001_0000, 32'h0001_0000));
    send(diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
    send(diag(32'h0000_0002, 32'h0001_0000, 32'h0001_0000));
    m = {9{32'hFFFF_FFFF}};
    send(m);
    m = {9{32'h7FFF_FFFF}};
    send(m);
    m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
         32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    send(m);
    m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send(m);
    m = {32'h0000_8000, 32'h0000_0000, 32'h0000_0001,
         32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000,
         32'h0000_0001, 32'h0000_0000, 32'h0000_8000};
    send(m);
    drain();
  endtask

  task automatic test_threshold_settings();
    logic [M3I_TW-1:0] levels[5];
    levels = '{31'd0, 31'h7FFF_FFFF, 31'd1 << 16, 31'd2, 31'd1};
    foreach (levels[k]) begin
      set_threshold(levels[k]);
      send('0);
      send(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
      send(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      repeat (20) send(rand_matrix());
      drain();
    end
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < 263; n++) begin
      gaps_on = !(n >= 150 && n < 250);
      send(rand_matrix());
    end
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_threshold_settings();
    set_threshold(M3I_TW'($urandom_range(31'h0000_FFFF)));
    test_random_stream();
    $display("sent %0d matrices over directed, threshold and random phases", sent);
    $display("checked %0d results, %0d of them singular", checked, singular_seen);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_cof.sv
hw/rtl/m3i_det.sv
hw/rtl/m3i_div_lane.sv
hw/rtl/matrix3x3_inverse.sv
hw/rtl/m3i_checker.sv
tb/sv/matrix3x3_inverse_tb.sv
